>>> sv/alias_table_sampler_macros.svh
// assertion helpers for the alias table sampler
`ifndef ALIAS_TABLE_SAMPLER_MACROS_SVH
`define ALIAS_TABLE_SAMPLER_MACROS_SVH
`ifndef SYNTHESIS
`define ATS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ATS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ATS_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define ATS_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> sv/ats_pkg.sv
package ats_pkg;
   localparam int MAX_ENTRIES_DEF = 1024;
   localparam int WEIGHT_BITS_DEF = 32;
   localparam int FRAC_BITS       = 40;
   localparam int BAR_W           = 64;
   localparam int IDX_W           = 10;
   localparam int WORD_W          = 64;
   localparam int WEIGHT_W        = 32;
   localparam int N_W             = 11;
   localparam logic [N_W-1:0] N_RESET = 11'd1024;
   localparam int REQ_DATA_W      = 112;
   localparam int RSP_DATA_W      = 16;
   localparam int SAMPLE_DIGITS   = 4;
   localparam logic MODE_LOAD     = 1'b0;
   localparam logic MODE_SAMPLE   = 1'b1;
   localparam logic KIND_BUILD    = 1'b0;
   localparam logic KIND_SAMPLE   = 1'b1;
   localparam logic [BAR_W-1:0] ONE_FX = 64'h1 << FRAC_BITS;
endpackage

>>> sv/ats_ram.sv
module ats_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> sv/alias_table_sampler.sv
// alias method sampler: load weights, build the alias table, draw weighted samples
// sample: accept, reduce the word mod n four bits at a time, read threshold and alias, then emit
// build: a sum pass over the n weights, then per entry a bit-serial restoring divide
//   (skipped when the sum is zero), then a pointer walk that pairs underfull and overfull bars
// one item at a time; the result register lets the next item in while a result waits
// synchronous reset, then a clearing pass over all MAX_ENTRIES entries fills threshold and alias
`include "alias_table_sampler_macros.svh"
module alias_table_sampler #(
   parameter int MAX_ENTRIES = ats_pkg::MAX_ENTRIES_DEF,
   parameter int WEIGHT_BITS = ats_pkg::WEIGHT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // entry_index [9:0], weight [41:10], random_word [105:42], zero fill
   input  logic [ats_pkg::REQ_DATA_W-1:0]  req_tdata,
   // mode
   input  logic                            req_tuser,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // chosen_index [9:0], zero_sum_error [10], zero fill
   output logic [ats_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // kind
   output logic                            rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ats_pkg::N_W-1:0]         csr_data
);
   localparam int AW     = $clog2(MAX_ENTRIES);
   localparam int CW     = $clog2(MAX_ENTRIES + 1);
   localparam int PW     = CW + 1;
   localparam int EW     = ((ats_pkg::N_W > CW) ? ats_pkg::N_W : CW) + 1;
   localparam int SUM_W  = WEIGHT_BITS + CW;
   localparam int NUM_W  = WEIGHT_BITS + CW;
   localparam int SH_W   = NUM_W + ats_pkg::FRAC_BITS;
   localparam int DVW    = $clog2(SH_W + 1);
   localparam int STEPS  = ats_pkg::WORD_W / ats_pkg::SAMPLE_DIGITS;
   localparam int MDW    = $clog2(STEPS + 1);
   localparam int IXW    = AW + ats_pkg::IDX_W + 1;
   localparam int BW     = ats_pkg::BAR_W;

   typedef enum logic [4:0] {
      ST_CLR, ST_IDLE, ST_SUM, ST_BAR_RD, ST_BAR_MUL, ST_BAR_DIV, ST_BAR_WR,
      ST_GS, ST_GS_RD, ST_GS_CK, ST_MS_RD, ST_MS_CK, ST_LOOP,
      ST_TG_RD, ST_TG_CK, ST_TM_SELF, ST_TM_RD, ST_TM_CK,
      ST_MOD, ST_SM_RD, ST_SM_CK, ST_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [ats_pkg::N_W-1:0] n_ff, n_in;
   logic [PW-1:0]          i_ff, i_in, g_ff, g_in, m_ff, m_in, mm_ff, mm_in;
   logic                   pend_ff, pend_in, zero_ff, zero_in, init_ff, init_in;
   logic [SUM_W-1:0]       sum_ff, sum_in, rem_ff, rem_in;
   logic [SH_W-1:0]        sh_ff, sh_in;
   logic [BW-1:0]          q_ff, q_in, bar_g_ff, bar_g_in, bar_m_ff, bar_m_in;
   logic [DVW-1:0]         dv_ff, dv_in;
   logic [ats_pkg::WORD_W-1:0] word_ff, word_in, wsh_ff, wsh_in;
   logic [CW-1:0]          xr_ff, xr_in;
   logic [MDW-1:0]         md_ff, md_in;
   logic [AW-1:0]          pick_ff, pick_in;
   logic                   kind_ff, kind_in;
   logic                   rsp_valid_ff, rsp_valid_in, rsp_kind_ff, rsp_kind_in;
   logic                   rsp_err_ff, rsp_err_in;
   logic [AW-1:0]          rsp_idx_ff, rsp_idx_in;

   // ram ports
   logic                   w_wr_en, w_rd_en, b_wr_en, b_rd_en, t_wr_en, t_rd_en;
   logic [AW-1:0]          w_wr_addr, w_rd_addr, b_wr_addr, b_rd_addr, t_wr_addr, t_rd_addr;
   logic [WEIGHT_BITS-1:0] w_wr_data, w_rd_data;
   logic [BW-1:0]          b_wr_data, b_rd_data, t_wr_data, t_rd_data;
   logic [AW-1:0]          a_wr_data, a_rd_data;

   logic                   req_acc;
   logic [ats_pkg::IDX_W-1:0] req_idx;
   logic [IXW-1:0]         idx_ext;
   logic [WEIGHT_BITS+ats_pkg::WEIGHT_W-1:0] w_ext;
   logic [EW-1:0]          n_ext, n_big;
   logic [CW-1:0]          n_act;
   logic [PW-1:0]          n_pw;
   logic [NUM_W-1:0]       num;
   logic [SUM_W:0]         rsh;
   logic                   qbit;
   logic [SUM_W-1:0]       rem_nx;
   logic [CW-1:0]          mod_r;
   logic [ats_pkg::WORD_W-1:0] mod_w;
   logic [BW-1:0]          new_g;
   logic [AW+ats_pkg::IDX_W-1:0] out_idx_ext;

   assign req_acc   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_idx   = req_tdata[ats_pkg::IDX_W-1:0];
   assign idx_ext   = {{(AW + 1){1'b0}}, req_idx};
   assign w_ext     = {{WEIGHT_BITS{1'b0}}, req_tdata[41:10]};

   // n = 0 acts as one, n above the table size is clipped
   assign n_ext = {{(EW - ats_pkg::N_W){1'b0}}, n_ff};
   always_comb begin
      if (n_ff == '0) begin
         n_big = EW'(1);
      end else if (n_ext > EW'(MAX_ENTRIES)) begin
         n_big = EW'(MAX_ENTRIES);
      end else begin
         n_big = n_ext;
      end
   end
   assign n_act = n_big[CW-1:0];
   assign n_pw  = {1'b0, n_act};

   assign num = NUM_W'(w_rd_data) * NUM_W'(n_act);

   // one restoring step of the scaling division
   assign rsh    = {rem_ff, sh_ff[SH_W-1]};
   assign qbit   = (rsh >= {1'b0, sum_ff});
   assign rem_nx = qbit ? SUM_W'(rsh - {1'b0, sum_ff}) : rsh[SUM_W-1:0];

   // four bits of word mod n per cycle
   always_comb begin
      logic [CW:0]                r;
      logic [ats_pkg::WORD_W-1:0] w;
      r = {1'b0, xr_ff};
      w = wsh_ff;
      for (int k = 0; k < ats_pkg::SAMPLE_DIGITS; k++) begin
         r = {r[CW-1:0], w[ats_pkg::WORD_W-1]};
         w = w << 1;
         if (r >= {1'b0, n_act}) begin
            r = r - {1'b0, n_act};
         end
      end
      mod_r = r[CW-1:0];
      mod_w = w;
   end

   assign new_g = bar_g_ff + bar_m_ff - ats_pkg::ONE_FX;

   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      i_in = i_ff;  g_in = g_ff;  m_in = m_ff;  mm_in = mm_ff;
      pend_in = 1'b0;  zero_in = zero_ff;  init_in = init_ff;
      sum_in = sum_ff;  rem_in = rem_ff;  sh_in = sh_ff;  q_in = q_ff;  dv_in = dv_ff;
      bar_g_in = bar_g_ff;  bar_m_in = bar_m_ff;
      word_in = word_ff;  wsh_in = wsh_ff;  xr_in = xr_ff;  md_in = md_ff;
      pick_in = pick_ff;  kind_in = kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in = rsp_kind_ff;  rsp_err_in = rsp_err_ff;  rsp_idx_in = rsp_idx_ff;

      w_wr_en = 1'b0;  w_wr_addr = idx_ext[AW-1:0];  w_wr_data = w_ext[WEIGHT_BITS-1:0];
      w_rd_en = 1'b0;  w_rd_addr = i_ff[AW-1:0];
      b_wr_en = 1'b0;  b_wr_addr = g_ff[AW-1:0];  b_wr_data = new_g;
      b_rd_en = 1'b0;  b_rd_addr = g_ff[AW-1:0];
      t_wr_en = 1'b0;  t_wr_addr = m_ff[AW-1:0];  t_wr_data = '1;  a_wr_data = m_ff[AW-1:0];
      t_rd_en = 1'b0;  t_rd_addr = xr_ff[AW-1:0];

      if (csr_valid) begin
         n_in = csr_data;
      end

      unique case (state_ff)
         ST_CLR: begin
            t_wr_en   = 1'b1;
            t_wr_addr = i_ff[AW-1:0];
            a_wr_data = i_ff[AW-1:0];
            i_in      = i_ff + PW'(1);
            if (i_ff == PW'(MAX_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser == ats_pkg::MODE_LOAD) begin
                  w_wr_en = (idx_ext < IXW'(MAX_ENTRIES));
                  if (req_tlast) begin
                     kind_in  = ats_pkg::KIND_BUILD;
                     sum_in   = '0;
                     i_in     = '0;
                     state_in = ST_SUM;
                  end
               end else begin
                  kind_in  = ats_pkg::KIND_SAMPLE;
                  word_in  = req_tdata[105:42];
                  wsh_in   = req_tdata[105:42];
                  xr_in    = '0;
                  md_in    = '0;
                  state_in = ST_MOD;
               end
            end
         end
         ST_SUM: begin
            if (pend_ff) begin
               sum_in = sum_ff + SUM_W'(w_rd_data);
            end
            if (i_ff < n_pw) begin
               w_rd_en = 1'b1;
               pend_in = 1'b1;
               i_in    = i_ff + PW'(1);
            end else if (!pend_ff) begin
               zero_in  = (sum_ff == '0);
               i_in     = '0;
               state_in = ST_BAR_RD;
            end
         end
         ST_BAR_RD: begin
            if (i_ff < n_pw) begin
               w_rd_en  = 1'b1;
               state_in = ST_BAR_MUL;
            end else begin
               g_in     = '0;
               init_in  = 1'b1;
               state_in = ST_GS_RD;
            end
         end
         ST_BAR_MUL: begin
            if (zero_ff) begin
               q_in     = ats_pkg::ONE_FX;
               state_in = ST_BAR_WR;
            end else begin
               sh_in    = {num, {ats_pkg::FRAC_BITS{1'b0}}};
               rem_in   = '0;
               q_in     = '0;
               dv_in    = '0;
               state_in = ST_BAR_DIV;
            end
         end
         ST_BAR_DIV: begin
            rem_in = rem_nx;
            sh_in  = sh_ff << 1;
            q_in   = {q_ff[BW-2:0], qbit};
            dv_in  = dv_ff + DVW'(1);
            if (dv_ff == DVW'(SH_W - 1)) begin
               state_in = ST_BAR_WR;
            end
         end
         ST_BAR_WR: begin
            b_wr_en   = 1'b1;
            b_wr_addr = i_ff[AW-1:0];
            b_wr_data = q_ff;
            i_in      = i_ff + PW'(1);
            state_in  = ST_BAR_RD;
         end
         ST_GS: begin
            if (g_ff < n_pw && bar_g_ff < ats_pkg::ONE_FX) begin
               g_in     = g_ff + PW'(1);
               state_in = ST_GS_RD;
            end else if (init_ff) begin
               m_in     = '0;
               state_in = ST_MS_RD;
            end else begin
               state_in = ST_LOOP;
            end
         end
         ST_GS_RD: begin
            if (g_ff < n_pw) begin
               b_rd_en  = 1'b1;
               state_in = ST_GS_CK;
            end else if (init_ff) begin
               m_in     = '0;
               state_in = ST_MS_RD;
            end else begin
               state_in = ST_LOOP;
            end
         end
         ST_GS_CK: begin
            bar_g_in = b_rd_data;
            state_in = ST_GS;
         end
         ST_MS_RD: begin
            b_rd_addr = m_ff[AW-1:0];
            if (m_ff < n_pw) begin
               b_rd_en  = 1'b1;
               state_in = ST_MS_CK;
            end else begin
               mm_in    = m_ff + PW'(1);
               init_in  = 1'b0;
               state_in = init_ff ? ST_LOOP : ST_GS;
            end
         end
         ST_MS_CK: begin
            bar_m_in = b_rd_data;
            if (b_rd_data >= ats_pkg::ONE_FX) begin
               m_in     = m_ff + PW'(1);
               state_in = ST_MS_RD;
            end else begin
               mm_in    = m_ff + PW'(1);
               init_in  = 1'b0;
               state_in = init_ff ? ST_LOOP : ST_GS;
            end
         end
         ST_LOOP: begin
            if (g_ff < n_pw && m_ff < n_pw) begin
               // pair the underfull bar m with the overfull bar g
               t_wr_en   = 1'b1;
               t_wr_data = {bar_m_ff[ats_pkg::FRAC_BITS-1:0],
                            {(BW - ats_pkg::FRAC_BITS){1'b0}}};
               a_wr_data = g_ff[AW-1:0];
               b_wr_en   = 1'b1;
               bar_g_in  = new_g;
               if (new_g >= ats_pkg::ONE_FX || mm_ff <= g_ff) begin
                  m_in     = mm_ff;
                  state_in = ST_MS_RD;
               end else begin
                  m_in     = g_ff;
                  bar_m_in = new_g;
                  state_in = ST_GS;
               end
            end else begin
               state_in = ST_TG_RD;
            end
         end
         ST_TG_RD: begin
            if (g_ff < n_pw) begin
               b_rd_en  = 1'b1;
               state_in = ST_TG_CK;
            end else if (m_ff < n_pw) begin
               state_in = ST_TM_SELF;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_TG_CK: begin
            t_wr_en   = (b_rd_data >= ats_pkg::ONE_FX);
            t_wr_addr = g_ff[AW-1:0];
            a_wr_data = g_ff[AW-1:0];
            g_in      = g_ff + PW'(1);
            state_in  = ST_TG_RD;
         end
         ST_TM_SELF: begin
            t_wr_en  = 1'b1;
            m_in     = mm_ff;
            state_in = ST_TM_RD;
         end
         ST_TM_RD: begin
            b_rd_addr = m_ff[AW-1:0];
            if (m_ff < n_pw) begin
               b_rd_en  = 1'b1;
               state_in = ST_TM_CK;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_TM_CK: begin
            t_wr_en  = (b_rd_data <= ats_pkg::ONE_FX);
            m_in     = m_ff + PW'(1);
            state_in = ST_TM_RD;
         end
         ST_MOD: begin
            xr_in  = mod_r;
            wsh_in = mod_w;
            md_in  = md_ff + MDW'(1);
            if (md_ff == MDW'(STEPS - 1)) begin
               state_in = ST_SM_RD;
            end
         end
         ST_SM_RD: begin
            t_rd_en  = 1'b1;
            state_in = ST_SM_CK;
         end
         ST_SM_CK: begin
            pick_in  = (word_ff < t_rd_data) ? xr_ff[AW-1:0] : a_rd_data;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_err_in   = (kind_ff == ats_pkg::KIND_BUILD) && zero_ff;
               rsp_idx_in   = (kind_ff == ats_pkg::KIND_BUILD) ? '0 : pick_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         n_ff         <= ats_pkg::N_RESET;
         i_ff         <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         i_ff         <= i_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      g_ff <= g_in;  m_ff <= m_in;  mm_ff <= mm_in;
      zero_ff <= zero_in;  init_ff <= init_in;
      sum_ff <= sum_in;  rem_ff <= rem_in;  sh_ff <= sh_in;  q_ff <= q_in;  dv_ff <= dv_in;
      bar_g_ff <= bar_g_in;  bar_m_ff <= bar_m_in;
      word_ff <= word_in;  wsh_ff <= wsh_in;  xr_ff <= xr_in;  md_ff <= md_in;
      pick_ff <= pick_in;  kind_ff <= kind_in;
      rsp_kind_ff <= rsp_kind_in;  rsp_err_ff <= rsp_err_in;  rsp_idx_ff <= rsp_idx_in;
   end

   assign out_idx_ext = {{ats_pkg::IDX_W{1'b0}}, rsp_idx_ff};
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tuser   = rsp_kind_ff;
   assign rsp_tdata   = {{(ats_pkg::RSP_DATA_W - ats_pkg::IDX_W - 1){1'b0}},
                         rsp_err_ff, out_idx_ext[ats_pkg::IDX_W-1:0]};

   ats_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_ENTRIES)) u_weight_ram (
      .clock(clock), .wr_en(w_wr_en), .wr_addr(w_wr_addr), .wr_data(w_wr_data),
      .rd_en(w_rd_en), .rd_addr(w_rd_addr), .rd_data(w_rd_data)
   );
   ats_ram #(.WIDTH(BW), .DEPTH(MAX_ENTRIES)) u_bar_ram (
      .clock(clock), .wr_en(b_wr_en), .wr_addr(b_wr_addr), .wr_data(b_wr_data),
      .rd_en(b_rd_en), .rd_addr(b_rd_addr), .rd_data(b_rd_data)
   );
   ats_ram #(.WIDTH(BW), .DEPTH(MAX_ENTRIES)) u_thr_ram (
      .clock(clock), .wr_en(t_wr_en), .wr_addr(t_wr_addr), .wr_data(t_wr_data),
      .rd_en(t_rd_en), .rd_addr(t_rd_addr), .rd_data(t_rd_data)
   );
   ats_ram #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_alias_ram (
      .clock(clock), .wr_en(t_wr_en), .wr_addr(t_wr_addr), .wr_data(a_wr_data),
      .rd_en(t_rd_en), .rd_addr(t_rd_addr), .rd_data(a_rd_data)
   );

   `ATS_ASSERT_IMP(a_pair_underfull, clock, reset, (state_ff == ST_LOOP && g_ff < n_pw && m_ff < n_pw), (bar_m_ff < ats_pkg::ONE_FX), "paired bar is not underfull")
   `ATS_ASSERT_IMP(a_mod_range, clock, reset, (state_ff == ST_SM_RD), (xr_ff < n_act), "sample index not below n")
   `ATS_ASSERT_NXT(a_emit_hold, clock, reset, (state_ff == ST_EMIT && rsp_valid_ff && !rsp_tready), (state_ff == ST_EMIT && rsp_valid_ff), "result overwritten while stalled")
endmodule

>>> bench/alias_table_sampler_tb.sv
module alias_table_sampler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int RANDOM_ITEMS = 1750;
   localparam int SETTLE = 200;

   typedef logic [ats_pkg::IDX_W-1:0]    index_type;
   typedef logic [ats_pkg::WEIGHT_W-1:0] weight_type;
   typedef logic [ats_pkg::WORD_W-1:0]   word_type;
   typedef logic [ats_pkg::N_W-1:0]      entries_type;

   typedef struct packed {
      logic      kind;
      index_type chosen;
      logic      zero_err;
   } outcome_type;

   class sampler_scoreboard;
      logic [63:0] weight_of [ats_pkg::MAX_ENTRIES_DEF];
      logic [63:0] thresh [ats_pkg::MAX_ENTRIES_DEF];
      index_type   alias_of [ats_pkg::MAX_ENTRIES_DEF];
      logic [63:0] bars [ats_pkg::MAX_ENTRIES_DEF];
      entries_type entries_reg;
      outcome_type pending[$];
      int errors, items, builds, zero_builds, draws;

      function new();
         entries_reg = ats_pkg::N_RESET;
         for (int i = 0; i < ats_pkg::MAX_ENTRIES_DEF; i++) begin
            weight_of[i] = '0;
            thresh[i] = '1;
            alias_of[i] = index_type'(i);
         end
      endfunction

      function int live_entries();
         if (entries_reg == 0) return 1;
         if (entries_reg > ats_pkg::MAX_ENTRIES_DEF) return ats_pkg::MAX_ENTRIES_DEF;
         return int'(entries_reg);
      endfunction

      function void note_entries(entries_type v);
         entries_reg = v;
      endfunction

      function bit rebuild();
         int n, g, m, mm, guard;
         logic [63:0] total;
         logic [127:0] quot;
         bit zero;
         n = live_entries();
         total = '0;
         for (int i = 0; i < n; i++) total += weight_of[i];
         zero = (total == 0);
         for (int i = 0; i < n; i++) begin
            if (zero) bars[i] = ats_pkg::ONE_FX;
            else begin
               quot = ({64'b0, weight_of[i] * 64'(n)} << ats_pkg::FRAC_BITS) / {64'b0, total};
               bars[i] = quot[63:0];
            end
         end
         for (g = 0; g < n && bars[g] < ats_pkg::ONE_FX; g++) ;
         for (m = 0; m < n && bars[m] >= ats_pkg::ONE_FX; m++) ;
         mm = m + 1;
         guard = 2 * n + 2;
         while (g < n && m < n && guard > 0) begin
            guard--;
            thresh[m] = (bars[m] & (ats_pkg::ONE_FX - 1)) << (64 - ats_pkg::FRAC_BITS);
            alias_of[m] = index_type'(g);
            bars[g] = bars[g] + bars[m] - ats_pkg::ONE_FX;
            if (bars[g] >= ats_pkg::ONE_FX || mm <= g) begin
               for (m = mm; m < n && bars[m] >= ats_pkg::ONE_FX; m++) ;
               mm = m + 1;
            end else begin
               m = g;
            end
            for (; g < n && bars[g] < ats_pkg::ONE_FX; g++) ;
         end
         for (; g < n; g++)
            if (bars[g] >= ats_pkg::ONE_FX) begin
               thresh[g] = '1;
               alias_of[g] = index_type'(g);
            end
         if (m < n) begin
            thresh[m] = '1;
            alias_of[m] = index_type'(m);
            for (m = mm; m < n; m++)
               if (bars[m] <= ats_pkg::ONE_FX) begin
                  thresh[m] = '1;
                  alias_of[m] = index_type'(m);
               end
         end
         return zero;
      endfunction

      function void note_item(logic mode, index_type idx, weight_type w,
                              logic last, word_type word);
         outcome_type o;
         int x;
         items++;
         if (mode == ats_pkg::MODE_LOAD) begin
            weight_of[idx] = {32'b0, w};
            if (!last) return;
            o.kind = ats_pkg::KIND_BUILD;
            o.chosen = '0;
            o.zero_err = rebuild();
            builds++;
            if (o.zero_err) zero_builds++;
         end else begin
            x = int'(word % 64'(live_entries()));
            o.kind = ats_pkg::KIND_SAMPLE;
            o.chosen = (word < thresh[x]) ? index_type'(x) : alias_of[x];
            o.zero_err = 1'b0;
            draws++;
         end
         pending.push_back(o);
      endfunction

      function void check_result(logic kind, logic [ats_pkg::RSP_DATA_W-1:0] data);
         outcome_type exp_o;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result kind %0d data %h", $time, kind, data);
            errors++;
            return;
         end
         exp_o = pending.pop_front();
         if (kind !== exp_o.kind) begin
            $display("%0t: kind expected %0d got %0d", $time, exp_o.kind, kind);
            errors++;
         end
         if (data[9:0] !== exp_o.chosen) begin
            $display("%0t: chosen_index expected %0d got %0d", $time, exp_o.chosen, data[9:0]);
            errors++;
         end
         if (data[10] !== exp_o.zero_err) begin
            $display("%0t: zero_sum_error expected %0d got %0d", $time, exp_o.zero_err,
                     data[10]);
            errors++;
         end
      endfunction
   endclass

   logic                           clock = 0;
   logic                           reset = 1;
   logic                           req_tvalid = 0;
   logic                           req_tready;
   logic [ats_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           req_tuser = 0;
   logic                           req_tlast = 0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 0;
   logic [ats_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;
   logic                           csr_valid = 0;
   logic                           csr_ready;
   entries_type                    csr_data = '0;

   sampler_scoreboard sb = new();
   bit  no_idle = 0;
   bit  long_hold = 0;
   int  cycles = 0;

   alias_table_sampler DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("alias_table_sampler test failed");
         $finish;
      end
   end

   // monitors see values from before this edge's updates
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_item(req_tuser, req_tdata[9:0], req_tdata[41:10], req_tlast,
                      req_tdata[105:42]);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tuser, rsp_tdata);
      if (!reset && csr_valid && csr_ready)
         sb.note_entries(csr_data);
   end

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 13);
   endfunction

   // receiver
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = draw_gap();
         if (long_hold) begin
            rsp_tready <= 0;
            repeat (3000) @(posedge clock);
            long_hold = 0;
         end else if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_item(logic mode, index_type idx, weight_type w,
                            logic last, word_type word);
      int gap;
      gap = draw_gap();
      req_tdata <= {6'b0, word, w, idx};
      req_tuser <= mode;
      req_tlast <= last;
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic word_type rand_word();
      word_type wd;
      wd = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: wd = wd & 64'hFFFF;
         1: wd = '1 - (wd & 64'hFF);
         default: ;
      endcase
      return wd;
   endfunction

   task automatic settle();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_entries(entries_type v);
      settle();
      csr_data <= v;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   function automatic weight_type pick_weight(int style, int i);
      case (style)
         0: return $urandom;
         1: return $urandom_range(0, 15);
         2: return '0;
         3: return (i == 0) ? '1 : $urandom_range(0, 3);
         4: return '1;
         default: return $urandom_range(0, 1) ? $urandom : 32'd0;
      endcase
   endfunction

   // program n, load every live entry, build, then draw, with some stray loads when noise is set
   task automatic run_phase(entries_type cfg, int style, int n_draws, bit noise);
      int n;
      set_entries(cfg);
      n = sb.live_entries();
      for (int i = 0; i < n; i++)
         send_item(ats_pkg::MODE_LOAD, index_type'(i), pick_weight(style, i), i == n - 1,
                   {$urandom, $urandom});
      for (int j = 0; j < n_draws; j++) begin
         if (noise && $urandom_range(0, 7) == 0)
            send_item(ats_pkg::MODE_LOAD, index_type'($urandom_range(0, 1023)), $urandom,
                      1'b0, {$urandom, $urandom});
         else
            send_item(ats_pkg::MODE_SAMPLE, index_type'($urandom_range(0, 1023)), $urandom,
                      1'($urandom_range(0, 1)), rand_word());
      end
   endtask

   initial begin
      int start_items, n_pick, phase;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // draws from the reset table answer word mod n
      send_item(ats_pkg::MODE_SAMPLE, '0, '0, 1'b0, '0);
      send_item(ats_pkg::MODE_SAMPLE, '1, '1, 1'b1, '1);
      send_item(ats_pkg::MODE_SAMPLE, 10'h155, 32'hAAAA5555, 1'b0, 64'h0123456789ABCDEF);
      run_phase(11'd1, 4, 2, 1'b0);
      run_phase(11'd0, 1, 2, 1'b0);
      run_phase(11'd3, 2, 3, 1'b0);
      run_phase(11'd2, 3, 3, 1'b0);
      run_phase(11'd4, 0, 3, 1'b0);

      start_items = sb.items;
      phase = 0;
      while (sb.items - start_items < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 9))
            0, 1: n_pick = $urandom_range(17, 64);
            default: n_pick = $urandom_range(1, 16);
         endcase
         if (phase == 3) begin
            // receiver holds off while the sender keeps offering items
            set_entries(entries_type'(n_pick));
            long_hold = 1;
            no_idle = 1;
            for (int j = 0; j < 40; j++)
               send_item(ats_pkg::MODE_SAMPLE, '0, '0, 1'b0, rand_word());
         end else if (phase == 6) begin
            run_phase(11'h7FF, 0, 30, 1'b1);
         end else begin
            run_phase(entries_type'(n_pick), $urandom_range(0, 5), $urandom_range(20, 60),
                      1'b1);
         end
         phase++;
      end

      settle();
      $display("ran %0d items: %0d table builds (%0d with zero sum), %0d draws",
               sb.items, sb.builds, sb.zero_builds, sb.draws);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("alias_table_sampler test passed");
      else
         $display("alias_table_sampler test failed");
      $finish;
   end
endmodule

>>> files.f
+incdir+sv
sv/ats_pkg.sv
sv/ats_ram.sv
sv/alias_table_sampler.sv
bench/alias_table_sampler_tb.sv
